FILE: hdl/mvfd_pkg.sv
package mvfd_pkg;

  typedef struct packed {
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic signed [31:0] z_coord;
    logic [1:0]         component;
    logic [3:0]         exp_x;
    logic [3:0]         exp_y;
    logic [3:0]         exp_z;
    logic signed [31:0] coefficient;
    logic               first_term;
    logic               last_term;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         row;
    logic signed [47:0] d_dx;
    logic signed [47:0] d_dy;
    logic signed [47:0] d_dz;
    logic signed [47:0] field_value;
    logic signed [47:0] curl_part;
    logic signed [47:0] divergence;
    logic               final_row;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BUILD,
    ST_M1,
    ST_M2,
    ST_WEIGH,
    ST_ACC,
    ST_CURL,
    ST_EMIT
  } state_e;

  localparam logic signed [47:0] AccMax = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] AccMin = 48'sh8000_0000_0000;
  localparam logic signed [31:0] QOne   = 32'sh4000_0000;

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    if (v > 50'(AccMax)) return AccMax;
    if (v < 50'(AccMin)) return AccMin;
    return v[47:0];
  endfunction

endpackage

FILE: hdl/monomial_vector_field_derivatives.sv
// A first term builds the power tables (powers 0..MAX_DEGREE per axis); each term
// then runs 4 passes of states M1, M2, WEIGH, ACC (value and three partials through
// one 32x32 multiplier); a last term adds state CURL plus three output transfers. A
// new item is taken only in idle, after the last is done. Reset clears accumulators
// and control; power tables are undefined until a first term writes them.
module monomial_vector_field_derivatives #(
  parameter int MAX_DEGREE = 15
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mvfd_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mvfd_pkg::out_item_t  out_data_o
);

  localparam int TLen = MAX_DEGREE + 1;
  localparam int IW   = $clog2(TLen);

  mvfd_pkg::state_e state_q, state_d;
  mvfd_pkg::in_item_t item_q;

  logic signed [31:0] pw_q [3][TLen];
  logic signed [47:0] jac_q [9];
  logic signed [47:0] val_q [3];

  logic [IW-1:0] bidx_q, bidx_d;
  logic [1:0]    baxis_q, baxis_d;
  logic [1:0]    pass_q, pass_d;
  logic [1:0]    orow_q, orow_d;
  logic signed [31:0] prod_q;
  logic signed [47:0] term_q;
  logic signed [47:0] curl_q [3];
  logic signed [47:0] div_q;

  logic signed [31:0] ma, mb;
  logic signed [63:0] mp;
  logic signed [31:0] q30;
  logic [4:0] ea, eb, ed;
  logic [3:0] mult;
  logic signed [31:0] rd_x, rd_y, rd_z;

  logic signed [47:0] wt;
  logic signed [64:0] ws;
  logic signed [52:0] scaled;

  function automatic logic signed [31:0] rnd30(input logic signed [63:0] p);
    logic signed [64:0] s;
    logic signed [34:0] r;
    s = 65'(p) + 65'sd536870912;
    r = s[64:30];
    if (r > 35'sd2147483647) return 32'sh7FFF_FFFF;
    if (r < -35'sd2147483648) return 32'sh8000_0000;
    return r[31:0];
  endfunction

  function automatic logic signed [31:0] tread(input logic signed [31:0] t [TLen],
                                               input logic [4:0] i);
    if (32'(i) < TLen) return t[i[IW-1:0]];
    return '0;
  endfunction

  // exponents for this pass: 0 value, 1..3 one axis lowered
  always_comb begin
    ea = {1'b0, item_q.exp_x};
    eb = {1'b0, item_q.exp_y};
    ed = {1'b0, item_q.exp_z};
    mult = 4'd1;
    unique case (pass_q)
      2'd1: begin ea = ea - 5'd1; mult = item_q.exp_x; end
      2'd2: begin eb = eb - 5'd1; mult = item_q.exp_y; end
      2'd3: begin ed = ed - 5'd1; mult = item_q.exp_z; end
      default: ;
    endcase
    rd_x = tread(pw_q[0], ea);
    rd_y = tread(pw_q[1], eb);
    rd_z = tread(pw_q[2], ed);
  end

  always_comb begin
    ma = prod_q;
    mb = item_q.coefficient;
    case (state_q)
      mvfd_pkg::ST_BUILD: begin
        ma = (bidx_q == '0) ? mvfd_pkg::QOne : pw_q[baxis_q][bidx_q - IW'(1)];
        mb = (baxis_q == 2'd0) ? item_q.x_coord :
             (baxis_q == 2'd1) ? item_q.y_coord : item_q.z_coord;
      end
      mvfd_pkg::ST_M1: begin ma = rd_x; mb = rd_y; end
      mvfd_pkg::ST_M2: begin ma = prod_q; mb = rd_z; end
      default: ;
    endcase
    mp  = ma * mb;
    q30 = rnd30(mp);
  end

  always_comb begin
    ws = 65'(mp) + 65'sd536870912;
    wt = 48'($signed(ws[64:30]));
    scaled = 53'(term_q) * $signed({1'b0, mult});
  end

  logic skip;
  assign skip = (pass_q != 2'd0) && (mult == 4'd0);

  always_comb begin
    state_d = state_q;
    bidx_d  = bidx_q;
    baxis_d = baxis_q;
    pass_d  = pass_q;
    orow_d  = orow_q;
    unique case (state_q)
      mvfd_pkg::ST_IDLE:
        if (in_valid_i) begin
          bidx_d = '0; baxis_d = '0; pass_d = '0; orow_d = '0;
          state_d = in_data_i.first_term ? mvfd_pkg::ST_BUILD : mvfd_pkg::ST_M1;
        end
      mvfd_pkg::ST_BUILD:
        if (bidx_q == IW'(MAX_DEGREE)) begin
          bidx_d = '0;
          if (baxis_q == 2'd2) state_d = mvfd_pkg::ST_M1;
          else baxis_d = baxis_q + 2'd1;
        end else begin
          bidx_d = bidx_q + IW'(1);
        end
      mvfd_pkg::ST_M1: state_d = mvfd_pkg::ST_M2;
      mvfd_pkg::ST_M2: state_d = mvfd_pkg::ST_WEIGH;
      mvfd_pkg::ST_WEIGH: state_d = mvfd_pkg::ST_ACC;
      mvfd_pkg::ST_ACC:
        if (pass_q == 2'd3)
          state_d = item_q.last_term ? mvfd_pkg::ST_CURL : mvfd_pkg::ST_IDLE;
        else begin
          pass_d = pass_q + 2'd1;
          state_d = mvfd_pkg::ST_M1;
        end
      mvfd_pkg::ST_CURL: state_d = mvfd_pkg::ST_EMIT;
      mvfd_pkg::ST_EMIT:
        if (!out_stall_i) begin
          if (orow_q == 2'd2) state_d = mvfd_pkg::ST_IDLE;
          else orow_d = orow_q + 2'd1;
        end
      default: state_d = mvfd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mvfd_pkg::ST_IDLE;
      bidx_q  <= '0;
      baxis_q <= '0;
      pass_q  <= '0;
      orow_q  <= '0;
      for (int i = 0; i < 9; i++) jac_q[i] <= '0;
      for (int i = 0; i < 3; i++) val_q[i] <= '0;
    end else begin
      state_q <= state_d;
      bidx_q  <= bidx_d;
      baxis_q <= baxis_d;
      pass_q  <= pass_d;
      orow_q  <= orow_d;
      if (state_q == mvfd_pkg::ST_IDLE && in_valid_i && in_data_i.first_term) begin
        for (int i = 0; i < 9; i++) jac_q[i] <= '0;
        for (int i = 0; i < 3; i++) val_q[i] <= '0;
      end
      if (state_q == mvfd_pkg::ST_ACC && item_q.component != 2'd3 && !skip) begin
        if (pass_q == 2'd0)
          val_q[item_q.component] <= mvfd_pkg::sat48(50'(val_q[item_q.component])
                                                    + 50'(scaled));
        else
          jac_q[4'(item_q.component) * 4'd3 + 4'(pass_q) - 4'd1] <=
            mvfd_pkg::sat48(50'(jac_q[4'(item_q.component) * 4'd3 + 4'(pass_q) - 4'd1])
                            + 50'(scaled));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == mvfd_pkg::ST_IDLE && in_valid_i) item_q <= in_data_i;
    if (state_q == mvfd_pkg::ST_BUILD) begin
      if (bidx_q == '0) pw_q[baxis_q][0] <= mvfd_pkg::QOne;
      else pw_q[baxis_q][bidx_q] <= q30;
    end
    if (state_q == mvfd_pkg::ST_M1 || state_q == mvfd_pkg::ST_M2) prod_q <= q30;
    if (state_q == mvfd_pkg::ST_WEIGH) term_q <= wt;
    if (state_q == mvfd_pkg::ST_CURL) begin
      curl_q[0] <= mvfd_pkg::sat48(50'(jac_q[7]) - 50'(jac_q[5]));
      curl_q[1] <= mvfd_pkg::sat48(50'(jac_q[2]) - 50'(jac_q[6]));
      curl_q[2] <= mvfd_pkg::sat48(50'(jac_q[3]) - 50'(jac_q[1]));
      div_q <= mvfd_pkg::sat48(50'(jac_q[0]) + 50'(jac_q[4]) + 50'(jac_q[8]));
    end
  end

  assign in_stall_o  = (state_q != mvfd_pkg::ST_IDLE);
  assign out_valid_o = (state_q == mvfd_pkg::ST_EMIT);

  always_comb begin
    out_data_o.row         = orow_q;
    out_data_o.d_dx        = jac_q[4'(orow_q) * 4'd3];
    out_data_o.d_dy        = jac_q[4'(orow_q) * 4'd3 + 4'd1];
    out_data_o.d_dz        = jac_q[4'(orow_q) * 4'd3 + 4'd2];
    out_data_o.field_value = val_q[orow_q];
    out_data_o.curl_part   = curl_q[orow_q];
    out_data_o.divergence  = div_q;
    out_data_o.final_row   = (orow_q == 2'd2);
  end

endmodule
